[design/tem_pkg.sv]
`default_nettype none
package tem_pkg;
	localparam int GLYPH_SLOTS = 256;
	localparam int MAX_LINES = 4;
	localparam int LINE_HEIGHT = 15;
	localparam logic [15:0] SAT16 = 16'hFFFF;
	localparam logic [15:0] CODE_SPACE = 16'd32;
	localparam logic [15:0] CODE_END0 = 16'd0;
	localparam logic [15:0] CODE_END1 = 16'd1;
	localparam logic [15:0] CODE_NEWLINE = 16'd3;
	localparam logic [15:0] CODE_STYLE = 16'd9;
	localparam logic [15:0] SPACE_WIDTH = 16'd5;
	localparam logic [12:0] SPACING_LIMIT = 13'hC00;
	localparam logic [11:0] SPACING_CLAMP = 12'h200;
	localparam logic REG_FRAMED = 1'b0;
	localparam logic REG_SPACING = 1'b1;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEXT = 1'b1;
	localparam logic KIND_DIM = 1'b0;
	localparam logic KIND_SPACING = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GLYPH,
		ST_FIN_RD,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? SAT16 : s[15:0];
	endfunction
endpackage
`default_nettype wire

[design/text_entry_measure.sv]
// text_entry_measure: measures one message of 16-bit text codes.
// Input channel (valid/ready): command 0 loads one glyph width table slot,
// command 1 carries one text code. Glyph widths live in a RAM with a
// registered read; per-line width and gap count live in a small line RAM.
// Output channel (valid/ready): on code 0 or 1 the block gives a dimensions
// word, then (when spacing_enable is set) one spacing word per line.
// A glyph code is handled as a RAM read, then an add. The message end gives
// the dimensions word the cycle after acceptance. Each spacing word then
// passes through a line RAM read, 24 restoring divide steps (one quotient
// bit each), a load of the output register and the output handshake.
// Input ready is low while a message end is in progress.
// Reset (arst_n low) clears all control state, style and line counters;
// config resets to framed 0, spacing_enable 1. The glyph table is not
// cleared; slots must be loaded before use.
// A stalled receiver holds the output word in its register; the block
// waits and loses nothing. Config writes take effect at once; the user must
// make them only while the block is idle; the block does not enforce it.
`default_nettype none
module text_entry_measure #(
	parameter int GLYPH_SLOTS = tem_pkg::GLYPH_SLOTS,
	parameter int MAX_LINES = tem_pkg::MAX_LINES,
	parameter int LINE_HEIGHT = tem_pkg::LINE_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic command,
	input wire logic [15:0] entry_code,
	input wire logic [7:0] glyph_index,
	input wire logic [7:0] glyph_width,
	output logic out_valid,
	input wire logic out_ready,
	output logic kind,
	output logic [15:0] total_width,
	output logic [15:0] total_height,
	output logic [1:0] line_index,
	output logic [11:0] spacing,
	output logic last
);
	localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int GW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam logic [LW-1:0] LAST_LINE = LW'(MAX_LINES - 1);
	localparam logic [15:0] LH = 16'(LINE_HEIGHT);

	tem_pkg::state_t state_q, state_d;

	logic framed_q, spacing_en_q;
	logic [15:0] style_q, height_q, widest_q, gaps_q, cur_w_q;
	logic [LW-1:0] line_q;
	logic [1:0] skip_q;
	logic style_pend_q;

	// glyph width RAM
	logic [7:0] glyph_mem [GLYPH_SLOTS];
	logic [7:0] glyph_rd_q;
	logic glyph_oob_q;
	// line RAM: {gap count plus one, width}
	logic [31:0] line_mem [MAX_LINES];
	logic [31:0] line_rd_q;

	logic [LW-1:0] fin_idx_q, fin_n_q;
	logic [17:0] span_q;
	// divider
	logic [23:0] div_num_q, div_quo_q;
	logic [16:0] div_rem_q;
	logic [15:0] div_den_q;
	logic [4:0] div_cnt_q;
	logic div_zero_q;

	logic in_fire, out_fire;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// text-code decode
	logic [15:0] code;
	logic is_text, take_style, take_skip, is_space, is_glyph, is_end, is_nl;
	logic is_skip1, is_skip2, is_stylecode;
	logic [15:0] slot16;
	assign code = entry_code;
	assign slot16 = code - tem_pkg::CODE_SPACE;
	assign is_text = in_fire && command == tem_pkg::CMD_TEXT;
	assign take_style = is_text && style_pend_q;
	assign take_skip = is_text && !style_pend_q && skip_q != 2'd0;
	assign is_space = is_text && !style_pend_q && skip_q == 2'd0
		&& code == tem_pkg::CODE_SPACE;
	assign is_glyph = is_text && !style_pend_q && skip_q == 2'd0
		&& code > tem_pkg::CODE_SPACE;
	logic plain;
	assign plain = is_text && !style_pend_q && skip_q == 2'd0;
	assign is_end = plain && (code == tem_pkg::CODE_END0 || code == tem_pkg::CODE_END1);
	assign is_nl = plain && code == tem_pkg::CODE_NEWLINE;
	assign is_skip2 = plain && (code == 16'd14 || code == 16'd28);
	assign is_skip1 = plain && (code == 16'd8 || code == 16'd10
		|| code == 16'd15 || code == 16'd17);
	assign is_stylecode = plain && code == tem_pkg::CODE_STYLE;

	// closing line write
	logic close_now;
	logic [15:0] widest_new;
	assign close_now = is_nl || is_end;
	assign widest_new = (widest_q < cur_w_q) ? cur_w_q : widest_q;

	logic [15:0] w_fin;
	assign w_fin = framed_q ? tem_pkg::sat_add16(widest_new, 16'd2) : widest_new;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tem_pkg::ST_IDLE: begin
				if (is_glyph) state_d = tem_pkg::ST_GLYPH;
				else if (is_end) state_d = tem_pkg::ST_EMIT;
			end
			tem_pkg::ST_GLYPH: state_d = tem_pkg::ST_IDLE;
			tem_pkg::ST_FIN_RD: state_d = tem_pkg::ST_DIV;
			tem_pkg::ST_DIV: if (div_cnt_q == 5'd0) state_d = tem_pkg::ST_EMIT;
			tem_pkg::ST_EMIT: begin
				if (out_fire) begin
					if (last) state_d = tem_pkg::ST_IDLE;
					else state_d = tem_pkg::ST_FIN_RD;
				end
			end
			default: state_d = tem_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == tem_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tem_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framed_q <= 1'b0;
			spacing_en_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == tem_pkg::REG_FRAMED) framed_q <= cfg_data;
			else spacing_en_q <= cfg_data;
		end
	end

	// glyph RAM
	always_ff @(posedge clk) begin
		if (in_fire && command == tem_pkg::CMD_LOAD && 32'(glyph_index) < GLYPH_SLOTS)
			glyph_mem[GW'(glyph_index)] <= glyph_width;
		glyph_rd_q <= glyph_mem[GW'(slot16)];
		glyph_oob_q <= 32'(slot16) >= GLYPH_SLOTS;
	end

	// line RAM: read ahead to the next line as a spacing word leaves
	logic [LW-1:0] fin_rd_idx;
	assign fin_rd_idx = (state_q == tem_pkg::ST_EMIT && out_fire
		&& kind == tem_pkg::KIND_SPACING) ? fin_idx_q + 1'b1 : fin_idx_q;
	always_ff @(posedge clk) begin
		if (close_now)
			line_mem[line_q] <= {tem_pkg::sat_add16(gaps_q, 16'd1), cur_w_q};
		line_rd_q <= line_mem[fin_rd_idx];
	end

	// glyph add
	logic [15:0] g_add;
	logic style_inc;
	assign style_inc = (style_q == 16'd1 || style_q == 16'd5);
	assign g_add = (glyph_oob_q ? 16'd0 : {8'd0, glyph_rd_q}) + {15'd0, style_inc};

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q <= '0;
			style_pend_q <= 1'b0;
			skip_q <= '0;
			line_q <= '0;
			height_q <= LH;
			widest_q <= '0;
			gaps_q <= '0;
			cur_w_q <= '0;
		end else begin
			if (take_style) begin
				style_q <= code;
				style_pend_q <= 1'b0;
			end
			if (take_skip) skip_q <= skip_q - 2'd1;
			if (is_skip2) skip_q <= 2'd2;
			if (is_skip1) skip_q <= 2'd1;
			if (is_stylecode) style_pend_q <= 1'b1;
			if (is_space) begin
				cur_w_q <= tem_pkg::sat_add16(cur_w_q, tem_pkg::SPACE_WIDTH);
				gaps_q <= tem_pkg::sat_add16(gaps_q, 16'd1);
			end
			if (state_q == tem_pkg::ST_GLYPH) cur_w_q <= tem_pkg::sat_add16(cur_w_q, g_add);
			if (is_nl) begin
				widest_q <= widest_new;
				if (line_q != LAST_LINE) line_q <= line_q + 1'b1;
				height_q <= tem_pkg::sat_add16(height_q, LH);
				gaps_q <= '0;
				cur_w_q <= '0;
			end
			if (is_end) begin
				line_q <= '0;
				height_q <= LH;
				widest_q <= '0;
				gaps_q <= '0;
				cur_w_q <= '0;
			end
		end
	end

	// finish sequencing and output register
	// free space lies in [-8, 65532]: bit 17 is the sign, 16 bits of magnitude
	logic [15:0] gc_rd, lw_rd;
	logic [17:0] free_s;
	assign gc_rd = line_rd_q[31:16];
	assign lw_rd = line_rd_q[15:0];
	assign free_s = span_q - {2'd0, lw_rd} - 18'd4;

	logic [16:0] rem_sh;
	assign rem_sh = {div_rem_q[15:0], div_num_q[23]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			kind <= tem_pkg::KIND_DIM;
			total_width <= '0;
			total_height <= '0;
			line_index <= '0;
			spacing <= '0;
			last <= 1'b0;
			span_q <= '0;
			fin_idx_q <= '0;
			fin_n_q <= '0;
			div_zero_q <= 1'b0;
			div_num_q <= '0;
			div_den_q <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (is_end) begin
				out_valid <= 1'b1;
				kind <= tem_pkg::KIND_DIM;
				total_width <= w_fin;
				total_height <= height_q;
				line_index <= '0;
				spacing <= '0;
				last <= !spacing_en_q;
				span_q <= ({2'd0, w_fin} + 18'd19 & 18'h3FFF8) - 18'd16;
				fin_idx_q <= '0;
				fin_n_q <= line_q;
			end
			if (state_q == tem_pkg::ST_EMIT && out_fire) begin
				out_valid <= 1'b0;
				if (kind == tem_pkg::KIND_SPACING) fin_idx_q <= fin_idx_q + 1'b1;
			end
			if (state_q == tem_pkg::ST_FIN_RD) begin
				div_zero_q <= gc_rd <= 16'd1;
				div_num_q <= {(free_s[17] ? 16'd0 : free_s[15:0]), 8'd0};
				div_den_q <= gc_rd - 16'd1;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_cnt_q <= 5'd24;
			end
			if (state_q == tem_pkg::ST_DIV) begin
				if (div_cnt_q != 5'd0) begin
					div_num_q <= {div_num_q[22:0], 1'b0};
					if (rem_sh >= {1'b0, div_den_q}) begin
						div_rem_q <= rem_sh - {1'b0, div_den_q};
						div_quo_q <= {div_quo_q[22:0], 1'b1};
					end else begin
						div_rem_q <= rem_sh;
						div_quo_q <= {div_quo_q[22:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q - 5'd1;
				end else begin
					out_valid <= 1'b1;
					kind <= tem_pkg::KIND_SPACING;
					total_width <= '0;
					total_height <= '0;
					line_index <= 2'(fin_idx_q);
					last <= fin_idx_q == fin_n_q;
					if (div_zero_q) spacing <= '0;
					else if (div_quo_q > 24'(tem_pkg::SPACING_LIMIT))
						spacing <= tem_pkg::SPACING_CLAMP;
					else spacing <= div_quo_q[11:0];
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(spacing))
		else $error("output word changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready || state_q == tem_pkg::ST_IDLE)
		else $error("input taken during message end");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tem_pkg::KIND_SPACING |-> spacing <= 12'hC00)
		else $error("spacing above limit");
endmodule
`default_nettype wire
